/* rtl/bb7s_pkg.sv */
// Shared types and constants for the 7x7 saturating box blur.
// Holds the channel payload structs, the register indexes and the stage metadata.
// No dependencies.
`timescale 1ns / 1ps

package bb7s_pkg;

  localparam int PIXEL_W     = 8;
  localparam int OUT_COL_W   = 10;
  localparam int OUT_ROW_W   = 12;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W    = 13;
  localparam int MAX_HEIGHT  = 4096;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 13;

  localparam int CFG_WIDTH_RESET  = 64;
  localparam int CFG_HEIGHT_RESET = 64;

  localparam int SCALE_MUL   = 210;
  localparam int SCALE_SHIFT = 8;

  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'hFF;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic               frame_start;
  } in_pixel_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]   blurred_value;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 frame_last;
  } out_pixel_t;

  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
  } pos_meta_t;

endpackage

/* rtl/bb7s_ram.sv */
// Generic simple dual-port RAM: one write port and one registered read port.
// Read data holds while read enable is low. No dependencies.
`timescale 1ns / 1ps

module bb7s_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bb7s_pos.sv */
// Frame size registers and raster position counters for the box blur.
// Produces the line store column address and per-pixel output metadata.
// Depends on bb7s_pkg.
`timescale 1ns / 1ps

module bb7s_pos
  import bb7s_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_write,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         advance,
  input  logic                         frame_start,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output pos_meta_t                    meta
);

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int LINES   = 2 * RADIUS;
  localparam int RESET_W = (CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET;

  logic [WW-1:0]        eff_w_r, eff_w_nxt;
  logic [HEIGHT_W-1:0]  eff_h_r, eff_h_nxt;
  logic [AW-1:0]        col_r, col_nxt;
  logic [OUT_ROW_W-1:0] row_r, row_nxt;
  logic [AW-1:0]        c_cur;
  logic [OUT_ROW_W:0]   r_tmp;
  logic [OUT_ROW_W-1:0] r_cur;
  logic [WW-1:0]        c_inc;
  logic [OUT_ROW_W:0]   r_inc;

  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    if (cfg_write) begin
      case (cfg_addr)
        CFG_IMAGE_WIDTH: begin
          if (cfg_wdata[WIDTH_REG_W-1:0] == '0) begin
            eff_w_nxt = WW'(1);
          end else if (32'(cfg_wdata[WIDTH_REG_W-1:0]) > MAX_WIDTH) begin
            eff_w_nxt = WW'(MAX_WIDTH);
          end else begin
            eff_w_nxt = WW'(cfg_wdata[WIDTH_REG_W-1:0]);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_wdata == '0) begin
            eff_h_nxt = HEIGHT_W'(1);
          end else if (32'(cfg_wdata) > MAX_HEIGHT) begin
            eff_h_nxt = HEIGHT_W'(MAX_HEIGHT);
          end else begin
            eff_h_nxt = cfg_wdata;
          end
        end
        default: begin
          eff_w_nxt = eff_w_r;
        end
      endcase
    end
  end

  always_comb begin
    c_cur = frame_start ? '0 : col_r;
    r_tmp = frame_start ? '0 : {1'b0, row_r};
    if (WW'(c_cur) >= eff_w_r) begin
      c_cur = '0;
      r_tmp = r_tmp + (OUT_ROW_W + 1)'(1);
    end
    if (r_tmp >= eff_h_r) begin
      r_tmp = '0;
    end
    r_cur = r_tmp[OUT_ROW_W-1:0];
    c_inc = WW'(c_cur) + WW'(1);
    r_inc = {1'b0, r_cur} + (OUT_ROW_W + 1)'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (c_inc >= eff_w_r) begin
        col_nxt = '0;
        row_nxt = (r_inc >= eff_h_r) ? '0 : r_inc[OUT_ROW_W-1:0];
      end else begin
        col_nxt = c_inc[AW-1:0];
        row_nxt = r_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(RESET_W);
      eff_h_r <= HEIGHT_W'(CFG_HEIGHT_RESET);
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  assign col          = c_cur;
  assign meta.emit    = (32'(c_cur) >= LINES) && (32'(r_cur) >= LINES);
  assign meta.last    = (WW'(c_cur) == eff_w_r - WW'(1))
                     && ({1'b0, r_cur} == eff_h_r - HEIGHT_W'(1));
  assign meta.out_col = OUT_COL_W'(c_cur) - OUT_COL_W'(RADIUS);
  assign meta.out_row = r_cur - OUT_ROW_W'(RADIUS);

endmodule

/* rtl/bb7s_win.sv */
// Window accumulator for the box blur: a shift line of column sums, the window
// sum and the reciprocal scaling with saturation. Depends on bb7s_pkg.
`timescale 1ns / 1ps

module bb7s_win
  import bb7s_pkg::*;
#(
  parameter int RADIUS = 3
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         load,
  input  logic [$clog2((2*RADIUS+1)*255+1)-1:0]        colsum,
  output logic [PIXEL_W-1:0]                           blurred
);

  localparam int WIN   = 2 * RADIUS + 1;
  localparam int CSW   = $clog2(WIN * 255 + 1);
  localparam int SUM_W = $clog2(WIN * WIN * 255 + 1);
  localparam int SCALE = (WIN * WIN * SCALE_MUL) >> SCALE_SHIFT;
  localparam int K     = SUM_W + $clog2(SCALE);
  localparam int RECIP = ((1 << K) + SCALE - 1) / SCALE;
  localparam int RW    = SUM_W + 2;
  localparam int PW    = SUM_W + RW;

  logic [CSW-1:0]   line_r [WIN];
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [PW-1:0]    prod;

  always_comb begin
    sum_nxt = SUM_W'(colsum);
    for (int i = 1; i < WIN; i++) begin
      sum_nxt = sum_nxt + SUM_W'(line_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WIN; i++) begin
        line_r[i] <= '0;
      end
    end else if (load) begin
      for (int i = 0; i < WIN - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[WIN-1] <= colsum;
      sum_r         <= sum_nxt;
    end
  end

  assign prod    = PW'(sum_r) * PW'(RECIP);
  assign blurred = (prod[PW-1:K+PIXEL_W] != '0) ? PIXEL_MAX : prod[K+PIXEL_W-1:K];

endmodule

/* rtl/box_blur_7x7_saturating_top.sv */
// Top level of the streaming 7x7 saturating box blur.
// Depends on bb7s_pkg, bb7s_pos, bb7s_ram and bb7s_win.
//
// Usage:
//   Pixels arrive on in_data in raster order, one transfer per cycle when
//   in_valid is high and in_stall is low. frame_start marks the first pixel
//   of a frame. The frame size is set through the cfg_ port (index 0: width,
//   index 1: height); cfg_ready is always high. The user must make writes only
//   while the block is idle; the block itself does not enforce this.
//   Each pixel at least RADIUS from every border gives one result on out_data,
//   holding the window sum divided by the scale and saturated to 255, with
//   the centre position and a flag on the last result of the frame.
//   Throughput is one pixel per cycle while in_stall is low, set by the line
//   store, which reads the column of the incoming pixel and writes back the
//   shifted column as each pixel leaves stage p1. A pixel passes the stage
//   registers p1, p2 and p3 and the output register before out_valid rises.
//   Reset clears the position counters and the window, and sets the size to
//   64 by 64. The line store is not cleared. When out_stall holds a result,
//   pixels that give no result and empty stages still drain, and in_stall
//   rises once the pipeline is full.
`timescale 1ns / 1ps

module box_blur_7x7_saturating_top
  import bb7s_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_pixel_t             in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_pixel_t            out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int LINES = 2 * RADIUS;
  localparam int LS_W  = LINES * PIXEL_W;
  localparam int CSW   = $clog2((2 * RADIUS + 1) * 255 + 1);

  logic            accept, rdy_out;
  logic            go1, go2, go3, free1, free2, free3;
  logic [AW-1:0]   pos_col;
  pos_meta_t       pos_meta;

  logic               p1_valid_r, p1_fwd_r;
  logic [PIXEL_W-1:0] p1_pix_r;
  logic [AW-1:0]      p1_col_r;
  logic [LS_W-1:0]    p1_fwd_data_r;
  pos_meta_t          p1_meta_r;

  logic               p2_valid_r;
  logic [CSW-1:0]     p2_colsum_r;
  pos_meta_t          p2_meta_r;

  logic               p3_valid_r;
  pos_meta_t          p3_meta_r;

  logic               out_valid_r;
  out_pixel_t         out_data_r;

  logic [LS_W-1:0]    ram_rdata, ls_word, ram_wdata;
  logic               ram_we;
  logic [CSW-1:0]     colsum;
  logic [PIXEL_W-1:0] blurred;

  assign cfg_ready = 1'b1;

  assign rdy_out = !out_valid_r || !out_stall;
  assign go3     = p3_valid_r && (!p3_meta_r.emit || rdy_out);
  assign free3   = !p3_valid_r || go3;
  assign go2     = p2_valid_r && free3;
  assign free2   = !p2_valid_r || free3;
  assign go1     = p1_valid_r && free2;
  assign free1   = !p1_valid_r || free2;
  assign accept  = in_valid && free1;
  assign in_stall = !free1;

  bb7s_pos #(
    .MAX_WIDTH(MAX_WIDTH),
    .RADIUS   (RADIUS)
  ) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .advance    (accept),
    .frame_start(in_data.frame_start),
    .col        (pos_col),
    .meta       (pos_meta)
  );

  assign ls_word   = p1_fwd_r ? p1_fwd_data_r : ram_rdata;
  assign ram_wdata = {p1_pix_r, ls_word[LS_W-1:PIXEL_W]};
  assign ram_we    = go1;

  bb7s_ram #(
    .WIDTH(LS_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(p1_col_r),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(pos_col),
    .rdata(ram_rdata)
  );

  always_comb begin
    colsum = CSW'(p1_pix_r);
    for (int i = 0; i < LINES; i++) begin
      colsum = colsum + CSW'(ls_word[PIXEL_W*i +: PIXEL_W]);
    end
  end

  bb7s_win #(
    .RADIUS(RADIUS)
  ) u_win (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (go2),
    .colsum (p2_colsum_r),
    .blurred(blurred)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free1) begin
        p1_valid_r <= accept;
      end
      if (free2) begin
        p2_valid_r <= go1;
      end
      if (free3) begin
        p3_valid_r <= go2;
      end
      if (go3 && p3_meta_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_pix_r      <= in_data.pixel_value;
      p1_col_r      <= pos_col;
      p1_meta_r     <= pos_meta;
      p1_fwd_r      <= ram_we && (p1_col_r == pos_col);
      p1_fwd_data_r <= ram_wdata;
    end
    if (go1) begin
      p2_colsum_r <= colsum;
      p2_meta_r   <= p1_meta_r;
    end
    if (go2) begin
      p3_meta_r <= p2_meta_r;
    end
    if (go3 && p3_meta_r.emit) begin
      out_data_r.blurred_value <= blurred;
      out_data_r.out_col       <= p3_meta_r.out_col;
      out_data_r.out_row       <= p3_meta_r.out_row;
      out_data_r.frame_last    <= p3_meta_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_fwd_same_column: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && accept && (p1_col_r == pos_col)) |=> p1_fwd_r)
    else $error("line store write was not forwarded to a read of the same column");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && !go1) |=> (p1_valid_r && $stable(p1_col_r)))
    else $error("held pixel left the line store stage");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (p3_valid_r && p3_meta_r.emit && !rdy_out) |=> p3_valid_r)
    else $error("result was dropped while the output was blocked");
`endif

endmodule
